// ===== sv/cdf_pkg.sv =====
// ----------------------------------------------------------------------------
// cdf_pkg: shared types, constants and table functions
// Holds the controller/datapath interface types and the elaboration-time
// generators for the cosine table and the log2 interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none
package cdf_pkg;

   localparam int NUM_BANDS_DEF  = 32;
   localparam int NUM_COEFFS_DEF = 13;

   localparam int MEL_W      = 24;
   localparam int ROM_W      = 18;
   localparam int COEF_W     = 32;
   localparam int IDX_W      = 4;
   localparam int ACC_W      = 48;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int TAB_W      = 17;
   localparam int TAB_DEPTH  = 65;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] REG_DB_MODE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEFFS  = 8'd1;
   localparam logic [3:0]           COEFFS_RESET = 4'd13;

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAC, ST_DRAIN, ST_SAT, ST_SQ, ST_NLOAD, ST_NORM,
      ST_LOOK, ST_INTERP, ST_SCALE, ST_ROUND, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_SAT, OP_SQ, OP_NLOAD, OP_NORM, OP_LOOK, OP_INTERP,
      OP_SCALE, OP_ROUND
   } op_type;

   typedef struct packed {
      logic             wr_en;
      logic             issue;
      logic             clear_acc;
      op_type           op;
      logic             emit;
      logic             last;
      logic [IDX_W-1:0] index;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic norm_done;
      logic out_full;
   } status_type;

   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], a[i]};
         if (r >= {1'b0, b}) begin
            r = r - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v, r, bit_v;
      v = v_in;
      r = '0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= r + bit_v) begin
            v = v - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] trig_q30(input logic [63:0] a, input logic want_sin);
      logic [63:0] a2, term, k;
      logic signed [63:0] sum;
      a2 = (a * a) >> 30;
      term = want_sin ? a : ONE_Q30;
      k = want_sin ? 64'd2 : 64'd1;
      sum = signed'(term);
      for (int i = 1; i <= 12; i++) begin
         term = udiv64((term * a2) >> 30, k * (k + 64'd1));
         k = k + 64'd2;
         if (i % 2 == 1) sum = sum - signed'(term);
         else sum = sum + signed'(term);
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   function automatic logic signed [ROM_W-1:0] rom_entry(input int nb, input int n,
                                                         input int m);
      logic [63:0] nb64, scale, ang, q, r, a, t, mag;
      logic neg;
      nb64 = 64'(nb);
      scale = isqrt64(udiv64(64'd1 << 61, nb64));
      ang = 64'((2 * m + 1) * n);
      while (ang >= 4 * nb64) ang = ang - 4 * nb64;
      q = '0;
      r = ang;
      while (r >= nb64) begin
         r = r - nb64;
         q = q + 64'd1;
      end
      a = udiv64(PI_Q30 * r + nb64, 2 * nb64);
      t = trig_q30(a, q[0]);
      mag = (scale * t + (64'd1 << 43)) >> 44;
      neg = (q == 64'd1) || (q == 64'd2);
      return neg ? -ROM_W'(mag) : ROM_W'(mag);
   endfunction

   function automatic logic [TAB_W-1:0] log2_entry(input int i);
      logic [63:0] y, res;
      if (i >= 64) return TAB_W'(65536);
      y = ONE_Q30 + (64'(i) << 24);
      res = '0;
      for (int b = 0; b < 20; b++) begin
         y = (y * y) >> 30;
         res = res << 1;
         if (y >= 2 * ONE_Q30) begin
            res = res | 64'd1;
            y = y >> 1;
         end
      end
      return TAB_W'((res + 64'd8) >> 4);
   endfunction

endpackage
`default_nettype wire

// ===== sv/cdf_datapath.sv =====
// ----------------------------------------------------------------------------
// cdf_datapath: band buffer, cosine table, MAC and dB conversion unit
// Executes the commands of the controller one step at a time and holds the
// result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
module cdf_datapath #(
   parameter int NUM_BANDS  = cdf_pkg::NUM_BANDS_DEF,
   parameter int NUM_COEFFS = cdf_pkg::NUM_COEFFS_DEF,
   localparam int BAW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
   localparam int ROM_D = NUM_COEFFS * NUM_BANDS,
   localparam int RAW   = (ROM_D > 1) ? $clog2(ROM_D) : 1
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire cdf_pkg::cmd_type            cmd,
   input  wire [BAW-1:0]                    wr_addr,
   input  wire [BAW-1:0]                    rd_addr,
   input  wire [RAW-1:0]                    rom_addr,
   input  wire [cdf_pkg::MEL_W-1:0]         wr_data,
   output cdf_pkg::status_type              status,
   output logic [cdf_pkg::RSP_DATA_W-1:0]   rsp_data,
   output logic                             rsp_valid,
   output logic                             rsp_last,
   input  wire                              rsp_ready
);

   logic [cdf_pkg::MEL_W-1:0]         band_mem [NUM_BANDS];
   logic signed [cdf_pkg::ROM_W-1:0]  rom_w [ROM_D];
   logic [cdf_pkg::TAB_W-1:0]         tab_w [cdf_pkg::TAB_DEPTH];

   for (genvar gn = 0; gn < NUM_COEFFS; gn++) begin : g_rom_n
      for (genvar gm = 0; gm < NUM_BANDS; gm++) begin : g_rom_m
         localparam logic signed [cdf_pkg::ROM_W-1:0] V = cdf_pkg::rom_entry(NUM_BANDS, gn, gm);
         assign rom_w[gn * NUM_BANDS + gm] = V;
      end
   end

   for (genvar gi = 0; gi < cdf_pkg::TAB_DEPTH; gi++) begin : g_tab
      localparam logic [cdf_pkg::TAB_W-1:0] V = cdf_pkg::log2_entry(gi);
      assign tab_w[gi] = V;
   end

   logic [cdf_pkg::MEL_W-1:0]         band_q_ff;
   logic signed [cdf_pkg::ROM_W-1:0]  rom_q_ff;
   logic                              rd_vld_ff;
   logic signed [42:0]                prod_ff;
   logic                              prod_vld_ff;
   logic signed [cdf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]                c_ff, c_in;
   logic [63:0]                       sq_ff;
   logic [62:0]                       x_ff, x_in;
   logic [5:0]                        p_ff, p_in;
   logic [cdf_pkg::TAB_W-1:0]         t0_ff;
   logic signed [cdf_pkg::TAB_W:0]    diff_ff;
   logic [15:0]                       f_ff;
   logic [21:0]                       l2_ff;
   logic [50:0]                       sp_ff;
   logic [cdf_pkg::RSP_DATA_W-1:0]    out_data_ff;
   logic                              out_last_ff;
   logic                              out_vld_ff, out_vld_in;

   logic signed [48:0]                sat_v;
   logic signed [32:0]                sat_r;
   logic [31:0]                       mag_w;
   logic [5:0]                        idx_w;
   logic signed [34:0]                dprod_w;
   logic signed [34:0]                drnd_w;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         band_mem[wr_addr] <= wr_data;
      end
      band_q_ff <= band_mem[rd_addr];
      rom_q_ff  <= rom_w[rom_addr];
      prod_ff   <= $signed({1'b0, band_q_ff}) * rom_q_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear_acc) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + cdf_pkg::ACC_W'(prod_ff);
      end
   end

   always_comb begin
      sat_v = 49'(acc_ff) + 49'sd32768;
      sat_r = 33'(sat_v >>> 16);
      mag_w = c_ff[31] ? 32'(-c_ff) : 32'(c_ff);
      idx_w = x_ff[61:56];
      dprod_w = 35'(diff_ff) * $signed({19'd0, f_ff});
      drnd_w = dprod_w + 35'sd32768;
      c_in = c_ff;
      x_in = x_ff;
      p_in = p_ff;
      unique case (cmd.op)
         cdf_pkg::OP_SAT: begin
            if (sat_r > 33'sd2147483647) c_in = 32'h7FFF_FFFF;
            else if (sat_r < -33'sd2147483648) c_in = 32'h8000_0000;
            else c_in = 32'(sat_r);
         end
         cdf_pkg::OP_NLOAD: begin
            x_in = (63'd1 << 32) + 63'(sq_ff);
            p_in = 6'd62;
         end
         cdf_pkg::OP_NORM: begin
            if (!x_ff[62]) begin
               x_in = {x_ff[61:0], 1'b0};
               p_in = p_ff - 6'd1;
            end
         end
         cdf_pkg::OP_ROUND: c_in = 32'((sp_ff + 51'd536870912) >> 30);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      c_ff   <= c_in;
      x_ff   <= x_in;
      p_ff   <= p_in;
      if (cmd.op == cdf_pkg::OP_SQ) begin
         sq_ff <= 64'(mag_w) * 64'(mag_w);
      end
      if (cmd.op == cdf_pkg::OP_LOOK) begin
         t0_ff   <= tab_w[7'(idx_w)];
         diff_ff <= $signed({1'b0, tab_w[7'(idx_w) + 7'd1]}) - $signed({1'b0, tab_w[7'(idx_w)]});
         f_ff    <= x_ff[55:40];
      end
      if (cmd.op == cdf_pkg::OP_INTERP) begin
         l2_ff <= (22'(p_ff - 6'd32) << 16) + 22'(t0_ff) + 22'(drnd_w >>> 16);
      end
      if (cmd.op == cdf_pkg::OP_SCALE) begin
         sp_ff <= 51'(l2_ff) * 51'(cdf_pkg::LOG10_2_Q30);
      end
      if (cmd.emit) begin
         out_data_ff <= cdf_pkg::RSP_DATA_W'({cmd.index, c_ff});
         out_last_ff <= cmd.last;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.emit) out_vld_in = 1'b1;
      else if (rsp_ready) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
         out_vld_ff  <= out_vld_in;
      end
   end

   assign status.pipe_busy = rd_vld_ff | prod_vld_ff;
   assign status.norm_done = x_ff[62];
   assign status.out_full  = out_vld_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_last  = out_last_ff;

endmodule
`default_nettype wire

// ===== sv/cdf_controller.sv =====
// ----------------------------------------------------------------------------
// cdf_controller: frame sequencer and configuration registers
// Counts bands, steps the MAC over bands and coefficients, walks the dB
// conversion steps and hands each coefficient to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module cdf_controller #(
   parameter int NUM_BANDS  = cdf_pkg::NUM_BANDS_DEF,
   parameter int NUM_COEFFS = cdf_pkg::NUM_COEFFS_DEF,
   localparam int BAW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
   localparam int ROM_D = NUM_COEFFS * NUM_BANDS,
   localparam int RAW   = (ROM_D > 1) ? $clog2(ROM_D) : 1,
   localparam int NW    = $clog2(NUM_COEFFS + 1)
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [cdf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [cdf_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire cdf_pkg::status_type           status,
   output cdf_pkg::cmd_type                   cmd,
   output logic [BAW-1:0]                     wr_addr,
   output logic [BAW-1:0]                     rd_addr,
   output logic [RAW-1:0]                     rom_addr
);

   cdf_pkg::state_type state_ff, state_in;
   logic [BAW-1:0] count_ff, count_in;
   logic [BAW-1:0] m_ff, m_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [RAW-1:0] base_ff, base_in;
   logic           db_ff;
   logic [3:0]     coeffs_ff;
   logic [5:0]     eff_w;
   logic           accept_w, frame_end_w, last_w;

   assign csr_ready   = 1'b1;
   assign accept_w    = req_tvalid & req_tready;
   assign frame_end_w = (count_ff == BAW'(NUM_BANDS - 1));
   assign eff_w       = (6'(coeffs_ff) > 6'(NUM_COEFFS)) ? 6'(NUM_COEFFS) : 6'(coeffs_ff);
   assign last_w      = (6'(n_ff) + 6'd1 == eff_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff     <= 1'b0;
         coeffs_ff <= cdf_pkg::COEFFS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cdf_pkg::REG_DB_MODE: db_ff <= csr_data[0];
            cdf_pkg::REG_COEFFS:  coeffs_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      base_in  = base_ff;
      unique case (state_ff)
         cdf_pkg::ST_IDLE: begin
            if (accept_w) begin
               if (frame_end_w) begin
                  count_in = '0;
                  m_in     = '0;
                  n_in     = '0;
                  base_in  = '0;
                  if (eff_w != 6'd0) state_in = cdf_pkg::ST_MAC;
               end else begin
                  count_in = count_ff + BAW'(1);
               end
            end
         end
         cdf_pkg::ST_MAC: begin
            m_in = m_ff + BAW'(1);
            if (m_ff == BAW'(NUM_BANDS - 1)) state_in = cdf_pkg::ST_DRAIN;
         end
         cdf_pkg::ST_DRAIN:  if (!status.pipe_busy) state_in = cdf_pkg::ST_SAT;
         cdf_pkg::ST_SAT:    state_in = db_ff ? cdf_pkg::ST_SQ : cdf_pkg::ST_EMIT;
         cdf_pkg::ST_SQ:     state_in = cdf_pkg::ST_NLOAD;
         cdf_pkg::ST_NLOAD:  state_in = cdf_pkg::ST_NORM;
         cdf_pkg::ST_NORM:   if (status.norm_done) state_in = cdf_pkg::ST_LOOK;
         cdf_pkg::ST_LOOK:   state_in = cdf_pkg::ST_INTERP;
         cdf_pkg::ST_INTERP: state_in = cdf_pkg::ST_SCALE;
         cdf_pkg::ST_SCALE:  state_in = cdf_pkg::ST_ROUND;
         cdf_pkg::ST_ROUND:  state_in = cdf_pkg::ST_EMIT;
         cdf_pkg::ST_EMIT: begin
            if (!status.out_full) begin
               if (last_w) begin
                  state_in = cdf_pkg::ST_IDLE;
               end else begin
                  state_in = cdf_pkg::ST_MAC;
                  n_in     = n_ff + NW'(1);
                  m_in     = '0;
                  base_in  = RAW'(32'(base_ff) + NUM_BANDS);
               end
            end
         end
         default: state_in = cdf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == cdf_pkg::ST_IDLE);
      cmd.wr_en     = accept_w;
      cmd.issue     = (state_ff == cdf_pkg::ST_MAC);
      cmd.clear_acc = (state_ff == cdf_pkg::ST_IDLE) || (state_ff == cdf_pkg::ST_EMIT);
      cmd.emit      = (state_ff == cdf_pkg::ST_EMIT) && !status.out_full;
      cmd.last      = last_w;
      cmd.index     = cdf_pkg::IDX_W'(n_ff);
      unique case (state_ff)
         cdf_pkg::ST_SAT:    cmd.op = cdf_pkg::OP_SAT;
         cdf_pkg::ST_SQ:     cmd.op = cdf_pkg::OP_SQ;
         cdf_pkg::ST_NLOAD:  cmd.op = cdf_pkg::OP_NLOAD;
         cdf_pkg::ST_NORM:   cmd.op = cdf_pkg::OP_NORM;
         cdf_pkg::ST_LOOK:   cmd.op = cdf_pkg::OP_LOOK;
         cdf_pkg::ST_INTERP: cmd.op = cdf_pkg::OP_INTERP;
         cdf_pkg::ST_SCALE:  cmd.op = cdf_pkg::OP_SCALE;
         cdf_pkg::ST_ROUND:  cmd.op = cdf_pkg::OP_ROUND;
         default:            cmd.op = cdf_pkg::OP_NONE;
      endcase
      wr_addr  = count_ff;
      rd_addr  = m_ff;
      rom_addr = RAW'(32'(base_ff) + 32'(m_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdf_pkg::ST_IDLE;
         count_ff <= '0;
         m_ff     <= '0;
         n_ff     <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         m_ff     <= m_in;
         n_ff     <= n_in;
         base_ff  <= base_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.out_full) else $error("emit into a full output register");
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (accept_w && frame_end_w && eff_w != 6'd0) |=> (state_ff == cdf_pkg::ST_MAC))
      else $error("frame end did not start the MAC");
   a_rom_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (32'(rom_addr) < ROM_D)) else $error("cosine table address out of range");
   a_no_issue_busy_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdf_pkg::ST_SAT) |-> !status.pipe_busy)
      else $error("accumulator read while MAC pipeline busy");

endmodule
`default_nettype wire

// ===== sv/cepstral_dct_frame_core.sv =====
// ----------------------------------------------------------------------------
// cepstral_dct_frame_core: DCT-II cepstrum of a frame of mel band energies
// Each band is one req transfer; after the last band of a frame the block
// sends min(coeffs_in_use, NUM_COEFFS) coefficients. Each coefficient runs
// NUM_BANDS band products through the single shared MAC, then pipeline drain,
// saturation and output handling, and in dB mode the remaining dB steps with
// the one-bit-per-cycle leading-one search. Bands are taken only while no
// frame is being computed.
// ----------------------------------------------------------------------------
`default_nettype none
module cepstral_dct_frame_core #(
   parameter int NUM_BANDS  = cdf_pkg::NUM_BANDS_DEF,
   parameter int NUM_COEFFS = cdf_pkg::NUM_COEFFS_DEF,
   localparam int BAW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
   localparam int ROM_D = NUM_COEFFS * NUM_BANDS,
   localparam int RAW   = (ROM_D > 1) ? $clog2(ROM_D) : 1
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [cdf_pkg::MEL_W-1:0]          req_tdata,  // [23:0] mel_value
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [cdf_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [31:0] coefficient, [35:32] coeff_index
   output logic                              rsp_tlast,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [cdf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [cdf_pkg::CSR_DATA_W-1:0]     csr_data
);

   cdf_pkg::cmd_type    cmd;
   cdf_pkg::status_type status;
   logic [BAW-1:0]      wr_addr;
   logic [BAW-1:0]      rd_addr;
   logic [RAW-1:0]      rom_addr;

   cdf_controller #(.NUM_BANDS(NUM_BANDS), .NUM_COEFFS(NUM_COEFFS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .rom_addr   (rom_addr)
   );

   cdf_datapath #(.NUM_BANDS(NUM_BANDS), .NUM_COEFFS(NUM_COEFFS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .rom_addr  (rom_addr),
      .wr_data   (req_tdata),
      .status    (status),
      .rsp_data  (rsp_tdata),
      .rsp_valid (rsp_tvalid),
      .rsp_last  (rsp_tlast),
      .rsp_ready (rsp_tready)
   );

endmodule
`default_nettype wire

// ===== tb/tb_cepstral_dct_frame_core.sv =====
// ----------------------------------------------------------------------------
// tb_cepstral_dct_frame_core: self-checking bench for the DCT-II cepstrum core
// Streams whole frames of mel band energies into the core with bursty
// traffic and a stalling receiver. An internal integer model predicts every
// coefficient, raw and in dB mode, for several register settings, and each
// response transfer is checked field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_cepstral_dct_frame_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BANDS      = 32;
   localparam int COEFFS     = 13;
   localparam int IDLE_WAIT  = 1500;
   localparam int WDOG_LIMIT = 20000;

   typedef struct {
      logic signed [cdf_pkg::COEF_W-1:0] coef;
      logic [cdf_pkg::IDX_W-1:0]         index;
      logic                              last;
   } coeff_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cdf_pkg::MEL_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cdf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cdf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cdf_pkg::CSR_DATA_W-1:0] csr_data = '0;

   cepstral_dct_frame_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   int                        cos_tab [COEFFS*BANDS];
   longint unsigned           log2_tab [65];
   logic [cdf_pkg::MEL_W-1:0] frame_bands [BANDS];
   int                        bands_seen;
   logic                      db_on;
   logic [3:0]                coeff_count;
   coeff_item_type            expected_coeffs [$];

   int errors;
   int burst_left;
   int idle_cycles;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned series_q30(longint unsigned a, bit odd);
      longint unsigned sq, term, k;
      longint signed acc;
      sq = (a * a) >> 30;
      term = odd ? a : (64'd1 << 30);
      k = odd ? 2 : 1;
      acc = term;
      for (int i = 1; i <= 12; i++) begin
         term = ((term * sq) >> 30) / (k * (k + 1));
         k = k + 2;
         if (i % 2) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      return (acc < 0) ? 0 : longint'(acc);
   endfunction

   task automatic build_model_tables();
      longint unsigned scale, ang, q, r, a, t, mag, y, res;
      scale = int_sqrt((64'd1 << 61) / BANDS);
      for (int n = 0; n < COEFFS; n++) begin
         for (int m = 0; m < BANDS; m++) begin
            ang = ((2 * m + 1) * n) % (4 * BANDS);
            q = ang / BANDS;
            r = ang % BANDS;
            a = (64'd3373259426 * r + BANDS) / (2 * BANDS);
            t = series_q30(a, q[0]);
            mag = (scale * t + (64'd1 << 43)) >> 44;
            cos_tab[n*BANDS+m] = (q == 1 || q == 2) ? -int'(mag) : int'(mag);
         end
      end
      for (int i = 0; i < 64; i++) begin
         y = (64'd1 << 30) + (longint'(i) << 24);
         res = 0;
         for (int b = 0; b < 20; b++) begin
            y = (y * y) >> 30;
            res = res << 1;
            if (y >= (64'd2 << 30)) begin
               res = res | 1;
               y = y >> 1;
            end
         end
         log2_tab[i] = (res + 8) >> 4;
      end
      log2_tab[64] = 65536;
   endtask

   function automatic logic signed [31:0] to_decibel(logic signed [31:0] c);
      longint unsigned mag, x, frac, idx, f, interp, l2;
      int p;
      mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
      x = (64'd1 << 32) + mag * mag;
      p = 62;
      while (x[p] == 1'b0) p--;
      frac = (x << (62 - p)) - (64'd1 << 62);
      idx = frac >> 56;
      f = (frac >> 40) & 64'hFFFF;
      interp = log2_tab[idx] + (((log2_tab[idx+1] - log2_tab[idx]) * f + 32768) >> 16);
      l2 = (longint'(p - 32) << 16) + interp;
      return 32'((l2 * 64'd323228497 + (64'd1 << 29)) >> 30);
   endfunction

   task automatic predict_band(logic [cdf_pkg::MEL_W-1:0] v);
      longint signed acc, rq;
      int cnt;
      coeff_item_type it;
      frame_bands[bands_seen] = v;
      bands_seen++;
      if (bands_seen < BANDS) return;
      bands_seen = 0;
      cnt = (coeff_count > COEFFS) ? COEFFS : coeff_count;
      for (int n = 0; n < cnt; n++) begin
         acc = 0;
         for (int m = 0; m < BANDS; m++)
            acc += longint'(frame_bands[m]) * longint'(cos_tab[n*BANDS+m]);
         rq = (acc + 32768) >>> 16;
         if (rq > 64'sd2147483647) rq = 64'sd2147483647;
         if (rq < -64'sd2147483648) rq = -64'sd2147483648;
         it.coef = 32'(rq);
         if (db_on) it.coef = to_decibel(it.coef);
         it.index = 4'(n);
         it.last = (n + 1 == cnt);
         expected_coeffs.push_back(it);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // response checker and receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      coeff_item_type w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 96;
         if (stall_phase < 24) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 2) != 0);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_coeffs.size() == 0) begin
               report_mismatch("unexpected transfer, coefficient", 
                               signed'(rsp_tdata[31:0]), 0);
            end else begin
               w = expected_coeffs.pop_front();
               if (rsp_tdata[31:0] !== w.coef)
                  report_mismatch("coefficient", signed'(rsp_tdata[31:0]), w.coef);
               if (rsp_tdata[35:32] !== w.index)
                  report_mismatch("coeff_index", rsp_tdata[35:32], w.index);
               if (rsp_tlast !== w.last)
                  report_mismatch("last_of_frame", rsp_tlast, w.last);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_band(logic [cdf_pkg::MEL_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata <= v;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_band(v);
   endtask

   task automatic hold_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_coeffs.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [cdf_pkg::CSR_IDX_W-1:0] idx,
                            logic [cdf_pkg::CSR_DATA_W-1:0] val);
      hold_idle();
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == cdf_pkg::REG_DB_MODE) db_on = val[0];
      else if (idx == cdf_pkg::REG_COEFFS) coeff_count = val[3:0];
   endtask

   task automatic send_frame(int kind);
      for (int m = 0; m < BANDS; m++) begin
         case (kind)
            0: send_band('0);
            1: send_band('1);
            2: send_band(m[0] ? '1 : '0);
            3: send_band(24'(1 << (m % 24)));
            default: begin
               if ($urandom_range(0, 7) == 0) send_band($urandom_range(0, 1) ? '1 : '0);
               else send_band(24'($urandom));
            end
         endcase
      end
   endtask

   task automatic test_defaults();
      send_frame(0);
      send_frame(1);
      send_frame(2);
   endtask

   task automatic test_db_mode();
      write_reg(cdf_pkg::REG_DB_MODE, 8'hFF);
      send_frame(1);
      send_frame(0);
      send_frame(3);
   endtask

   task automatic test_coeff_count();
      write_reg(cdf_pkg::REG_COEFFS, 8'd0);
      send_frame(4);
      write_reg(cdf_pkg::REG_COEFFS, 8'd15);
      send_frame(4);
      write_reg(cdf_pkg::REG_DB_MODE, 8'h00);
      write_reg(cdf_pkg::REG_COEFFS, 8'd1);
      send_frame(1);
      write_reg(cdf_pkg::REG_COEFFS, 8'hFE);
      send_frame(4);
   endtask

   task automatic test_bad_index();
      write_reg(8'd2, 8'hFF);
      write_reg(8'hFF, 8'h00);
      send_frame(4);
   endtask

   task automatic test_random();
      for (int k = 0; k < 4; k++) begin
         if (k % 2 == 0) begin
            write_reg($urandom_range(0, 1) ? cdf_pkg::REG_DB_MODE : 8'($urandom),
                      8'($urandom));
            write_reg(cdf_pkg::REG_COEFFS, 8'($urandom));
         end
         send_frame($urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : 4);
      end
   endtask

   initial begin
      errors = 0;
      burst_left = 0;
      bands_seen = 0;
      db_on = 1'b0;
      coeff_count = cdf_pkg::COEFFS_RESET;
      build_model_tables();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_db_mode();
      test_coeff_count();
      test_bad_index();
      test_random();
      hold_idle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/cdf_pkg.sv
sv/cdf_datapath.sv
sv/cdf_controller.sv
sv/cepstral_dct_frame_core.sv
tb/tb_cepstral_dct_frame_core.sv
